// File: rtl/lis_length_patience_tails_top_macros.svh
// assertion macros for the lis tail-table block
// used by lis_length_patience_tails_top, no other dependencies
`ifndef LIS_LENGTH_PATIENCE_TAILS_TOP_MACROS_SVH
`define LIS_LENGTH_PATIENCE_TAILS_TOP_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define LISPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define LISPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lispt_pkg.sv
// shared constants, types and sequencer states for the lis tail-table block
// no dependencies
package lispt_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int VALUE_W   = 32;
    localparam int OUT_LEN_W = 11;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [OUT_LEN_W-1:0]      t_out_len;
    typedef logic [LEN_W-1:0]          t_len;
    typedef logic [ADDR_W-1:0]         t_addr;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAIL,
        S_SEARCH,
        S_DONE
    } t_state;

    // tail memory access from the sequencer
    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_value wdata;
        t_addr  raddr;
    } t_ram_req;

    // finished result handed to the output register
    typedef struct packed {
        logic     load;
        t_out_len lis_length;
        logic     overflow;
    } t_result;

endpackage

// File: rtl/lispt_ifs.sv
// valid/ready channel interfaces for input items and results
// depends on lispt_pkg
interface lispt_in_if import lispt_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value value;
    logic   last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface lispt_out_if import lispt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_out_len lis_length;
    logic     overflow;

    modport source (output valid, output lis_length, output overflow, input ready);
    modport sink   (input valid, input lis_length, input overflow, output ready);
endinterface

// File: rtl/lispt_tail_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module lispt_tail_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lispt_ctrl.sv
// sequencer with the shared signed comparator: tail check, lower-bound search,
// append/replace write-back and result hand-off; depends on lispt_pkg
module lispt_ctrl import lispt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_value   i_value,
    input  logic     i_last,
    output logic     o_in_ready,
    input  logic     i_out_free,
    output t_result  o_res,
    output t_ram_req o_ram,
    input  t_value   i_rd_data
);

    t_state r_state, n_state;
    t_value r_key;
    logic   r_last;
    t_len   r_used, n_used;
    logic   r_ovf, n_ovf;
    t_len   r_lo, n_lo;
    t_len   r_hi, n_hi;
    t_addr  r_mid, n_mid;

    logic   c_key_gt;
    logic   s_append;
    logic   s_found;
    t_len   s_used_m1;
    t_len   s_mid_full;

    // the one comparator, shared by the tail check and every search step
    assign c_key_gt = r_key > i_rd_data;

    assign s_used_m1  = r_used - t_len'(1);
    assign s_append   = (r_used == '0) || c_key_gt;
    assign s_mid_full = n_lo + ((n_hi - n_lo) >> 1);
    assign s_found    = !(n_lo < n_hi);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = s_append ? S_DONE : S_SEARCH;
            end
            S_SEARCH: begin
                if (s_found) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_last || i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_in_ready       = 1'b0;
        o_ram.we         = 1'b0;
        o_ram.waddr      = r_used[ADDR_W-1:0];
        o_ram.wdata      = r_key;
        o_ram.raddr      = r_mid;
        o_res.load       = 1'b0;
        o_res.lis_length = OUT_LEN_W'(r_used);
        o_res.overflow   = r_ovf;
        n_used           = r_used;
        n_ovf            = r_ovf;
        n_lo             = r_lo;
        n_hi             = r_hi;
        n_mid            = r_mid;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_ram.raddr = s_used_m1[ADDR_W-1:0];
            end
            S_TAIL: begin
                n_lo = '0;
                n_hi = r_used;
                if (s_append) begin
                    if (r_used < t_len'(MAX_LEN)) begin
                        o_ram.we = 1'b1;
                        n_used   = r_used + t_len'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else begin
                    n_mid       = s_mid_full[ADDR_W-1:0];
                    o_ram.raddr = n_mid;
                end
            end
            S_SEARCH: begin
                if (c_key_gt) begin
                    n_lo = t_len'(r_mid) + t_len'(1);
                end else begin
                    n_hi = t_len'(r_mid);
                end
                n_mid       = s_mid_full[ADDR_W-1:0];
                o_ram.raddr = n_mid;
                o_ram.waddr = n_lo[ADDR_W-1:0];
                o_ram.we    = s_found;
            end
            S_DONE: begin
                if (r_last && i_out_free) begin
                    o_res.load = 1'b1;
                    n_used     = '0;
                    n_ovf      = 1'b0;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_key  <= i_value;
            r_last <= i_last;
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
    end

endmodule

// File: rtl/lis_length_patience_tails_top.sv
// top level of the longest-increasing-subsequence length block
// depends on lispt_pkg, lispt_ifs, lispt_ctrl, lispt_tail_ram and the macros header
//
// usage
//   in_ch  : sink of (value, last), one signed 32-bit element per transfer
//   out_ch : source of (lis_length, overflow), one transfer per sequence,
//            produced by the element that carries last
//   the block keeps the smallest tail of every increasing-subsequence length in
//   a 1024-entry memory; an element above the last tail is appended, otherwise it
//   replaces the first tail that is not below it (lower-bound search)
//   flow: ready is high only while the sequencer idles, so a new element is taken
//   only once the last is through; an append passes the tail check and done
//   states, a search the tail check, up to ADDR_W + 1 halving steps, each one
//   read of the single tail memory read port, and done, where a last element
//   waits until the output register is free; its result loads there for out_ch
//   reset: sequencer idle, table length and overflow flag cleared, no result
//   pending; the memory itself is not cleared, entries are only read once written
//   receiver stall: the result waits in the output register while new elements
//   keep flowing; a second result waits in the sequencer until the first leaves
module lis_length_patience_tails_top import lispt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lispt_in_if.sink    in_ch,
    lispt_out_if.source out_ch
);

`include "lis_length_patience_tails_top_macros.svh"

    t_ram_req ram_req;
    t_result  res;
    t_value   rd_data;
    logic     out_free;

    logic     r_out_valid;
    t_out_len r_out_len;
    logic     r_out_ovf;

    // output register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || out_ch.ready;

    lispt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_value    (in_ch.value),
        .i_last     (in_ch.last),
        .o_in_ready (in_ch.ready),
        .i_out_free (out_free),
        .o_res      (res),
        .o_ram      (ram_req),
        .i_rd_data  (rd_data)
    );

    // tail table, one write and one read per cycle
    lispt_tail_ram #(
        .DEPTH (MAX_LEN),
        .WIDTH (VALUE_W)
    ) u_tail_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    // result register decouples the receiver from the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_out_len <= res.lis_length;
            r_out_ovf <= res.overflow;
        end
    end

    assign out_ch.valid      = r_out_valid;
    assign out_ch.lis_length = r_out_len;
    assign out_ch.overflow   = r_out_ovf;

    // a new result never overwrites one the receiver has not taken
    `LISPT_ASSERT_IMP(a_no_clobber, res.load && r_out_valid, out_ch.ready, "result overwritten")
    // the sequencer is busy right after taking an element
    `LISPT_ASSERT_NXT(a_busy_after_xfer, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after transfer")
    // every sequence holds at least one element
    `LISPT_ASSERT_IMP(a_len_nonzero, r_out_valid, r_out_len != '0, "zero length result")

endmodule
